FILE: rtl/dsd_pkg.sv
// ----------------------------------------------------------------------------
// Dense submatrix density package
// Shared types, command codes and fixed widths of the density block.
// ----------------------------------------------------------------------------
package dsd_pkg;

  // Fixed field widths.
  localparam int OUT_W      = 50;
  localparam int TOPK_W     = 7;
  localparam int MSIZE_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Score arithmetic: the squared sum is scaled by 2^32 and saturates at 2^96.
  localparam int FRAC_SH = 32;
  localparam int SAT_SH  = 96;

  // Command fields are sized for the largest legal parameter values.
  localparam int LINE_W_MAX = 8;
  localparam int FLAT_W_MAX = 16;
  localparam int SEED_W_MAX = 10;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_K       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 2'd1;

  localparam logic [TOPK_W-1:0]  TOP_K_RST = 7'd1;
  localparam logic [MSIZE_W-1:0] MSIZE_RST = 6'd32;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SRCH_INIT,
    OP_SEL_CLR,
    OP_SEL,
    OP_SEL_END,
    OP_SEED_RD,
    OP_INIT_SUM,
    OP_INIT_ROW,
    OP_INIT_COL,
    OP_SCORE_GO,
    OP_SCAN_CLR,
    OP_SCAN,
    OP_DECIDE,
    OP_UPDATE
  } op_e;

  typedef enum logic [3:0] {
    S_LOAD,
    S_GAP,
    S_SRCH_INIT,
    S_SEL_CLR,
    S_SEL,
    S_SEL_END,
    S_SEED_RD,
    S_INIT_SUM,
    S_INIT_LINES,
    S_SCORE_GO,
    S_SCORE_WAIT,
    S_SCAN_CLR,
    S_SCAN,
    S_DECIDE,
    S_UPDATE,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_SQUARE,
    SC_ADD,
    SC_CMP,
    SC_DONE
  } sc_state_e;

  typedef struct packed {
    op_e                   op;
    logic [FLAT_W_MAX-1:0] flat;
    logic [LINE_W_MAX-1:0] row;
    logic [LINE_W_MAX-1:0] col;
    logic [SEED_W_MAX-1:0] seed;
  } cmd_t;

  typedef struct packed {
    logic score_done;
  } stat_t;

endpackage

FILE: rtl/dsd_in_if.sv
// ----------------------------------------------------------------------------
// Cell input channel
// Valid/ready channel that carries one matrix cell count per word.
// ----------------------------------------------------------------------------
interface dsd_in_if #(
  parameter int CW = 24
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] cell_count;

  modport source (output valid, output cell_count, input ready);
  modport sink   (input valid, input cell_count, output ready);
endinterface

FILE: rtl/dsd_out_if.sv
// ----------------------------------------------------------------------------
// Density output channel
// Valid/ready channel that carries one density result per word.
// ----------------------------------------------------------------------------
interface dsd_out_if;
  logic                    valid;
  logic                    ready;
  logic [dsd_pkg::OUT_W-1:0] best_density;

  modport source (output valid, output best_density, input ready);
  modport sink   (input valid, input best_density, output ready);
endinterface

FILE: rtl/dsd_score.sv
// ----------------------------------------------------------------------------
// Density score unit
// Computes floor(sqrt(sum^2 * 2^32 / d)) with a shift-add square and a
// bit-by-bit root that needs only adds, shifts and one compare per bit.
// ----------------------------------------------------------------------------
module dsd_score #(
  parameter int SUMW = 34,
  parameter int DW   = 11
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [SUMW-1:0]           sum_i,
  input  logic [DW-1:0]             d_i,
  output logic                      done_o,
  output logic [dsd_pkg::OUT_W-1:0] y_o
);
  import dsd_pkg::*;

  localparam int SQW  = 2 * SUMW;
  localparam int TW   = SQW + FRAC_SH;
  localparam int RW   = 2 * OUT_W + DW;
  localparam int PW   = ((TW > RW) ? TW : RW) + 2;
  localparam int CNTW = $clog2(SUMW + 1);

  sc_state_e state_q, state_d;

  logic [SQW-1:0]   mcand_q;
  logic [SUMW-1:0]  mplier_q;
  logic [SQW-1:0]   acc_q;
  logic [CNTW-1:0]  cnt_q;
  logic [PW-1:0]    p_q, qs_q, d2_q, cand_q;
  logic [OUT_W-1:0] ybit_q, y_q;
  logic [PW-1:0]    t_val, qs_acc;
  logic             sat;

  assign t_val  = PW'(acc_q) << FRAC_SH;
  assign sat    = (acc_q >> SAT_SH) != '0;
  assign qs_acc = (cand_q <= t_val) ? (qs_q + (d2_q << 1)) : qs_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SC_IDLE:   if (start_i) state_d = SC_SQUARE;
      SC_SQUARE: if (cnt_q == CNTW'(1)) state_d = SC_ADD;
      SC_ADD:    state_d = SC_CMP;
      SC_CMP:    state_d = ybit_q[0] ? SC_DONE : SC_ADD;
      SC_DONE:   state_d = SC_IDLE;
      default:   state_d = SC_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == SC_DONE);
    y_o    = sat ? '1 : y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SC_IDLE: begin
        mcand_q  <= SQW'(sum_i);
        mplier_q <= sum_i;
        acc_q    <= '0;
        cnt_q    <= CNTW'(SUMW);
      end
      SC_SQUARE: begin
        if (mplier_q[0]) acc_q <= acc_q + mcand_q;
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
        cnt_q    <= cnt_q - CNTW'(1);
        p_q      <= '0;
        qs_q     <= '0;
        d2_q     <= PW'(d_i) << (2 * (OUT_W - 1));
        ybit_q   <= OUT_W'(1) << (OUT_W - 1);
        y_q      <= '0;
      end
      SC_ADD: begin
        cand_q <= p_q + qs_q + d2_q;
      end
      SC_CMP: begin
        if (cand_q <= t_val) begin
          p_q <= cand_q;
          y_q <= y_q | ybit_q;
        end
        qs_q   <= qs_acc >> 1;
        d2_q   <= d2_q >> 2;
        ybit_q <= ybit_q >> 1;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/dsd_datapath.sv
// ----------------------------------------------------------------------------
// Density datapath
// Cell memory, seed memory, line partial sums, marks and the score unit.
// Reads are issued from the incoming command; the registered command acts
// on the read data in the cycle after.
// ----------------------------------------------------------------------------
module dsd_datapath #(
  parameter int MATRIX_DIM  = 32,
  parameter int COUNT_WIDTH = 24,
  parameter int MAX_SEEDS   = 64,
  localparam int NW         = $clog2(MATRIX_DIM + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dsd_pkg::cmd_t             cmd_i,
  input  logic [NW-1:0]             n_i,
  input  logic [COUNT_WIDTH-1:0]    cell_i,
  output dsd_pkg::stat_t            stat_o,
  output logic [dsd_pkg::OUT_W-1:0] best_o
);
  import dsd_pkg::*;

  localparam int LW    = $clog2(MATRIX_DIM);
  localparam int CELLS = MATRIX_DIM * MATRIX_DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int PSW   = COUNT_WIDTH + LW;
  localparam int SUMW  = COUNT_WIDTH + 2 * LW;
  localparam int DW    = $clog2(CELLS + 1);

  logic [COUNT_WIDTH-1:0] cmem [CELLS];
  logic [2*LW-1:0]        seed_mem [MAX_SEEDS];
  logic [PSW-1:0]         rps [MATRIX_DIM];
  logic [PSW-1:0]         cps [MATRIX_DIM];

  cmd_t                   cmd_q;
  logic [COUNT_WIDTH-1:0] cell_rd_q;
  logic [2*LW-1:0]        seed_rd_q;
  logic [PSW-1:0]         rps_rd_q, cps_rd_q;

  logic [LW-1:0]  a_row, a_col, line_i, line_q;
  logic           direct;
  logic [AW-1:0]  rd_addr;

  // Seed selection.
  logic                   first_q, found_q;
  logic [COUNT_WIDTH-1:0] cand_cnt_q, lim_cnt_q;
  logic [AW-1:0]          cand_flat_q, lim_flat_q;
  logic [LW-1:0]          cand_r_q, cand_c_q;
  logic                   sel_gt, sel_lt, sel_take;

  // Growth.
  logic [LW-1:0]         src_q, dst_q, br_q, bc_q, pick_q;
  logic                  pick_row_q, hr_q, hc_q;
  logic [PSW-1:0]        rv_q, cv_q;
  logic [MATRIX_DIM-1:0] row_mark_q, col_mark_q;
  logic [NW-1:0]         rows_q, cols_q;
  logic [SUMW-1:0]       sum_q;
  logic [DW-1:0]         d_q;
  logic [OUT_W-1:0]      best_q, score_y;
  logic                  score_done, take_row;

  assign line_i = cmd_i.row[LW-1:0];
  assign line_q = cmd_q.row[LW-1:0];

  // Cell address for the current command.
  always_comb begin
    direct = 1'b0;
    a_row  = line_i;
    a_col  = cmd_i.col[LW-1:0];
    unique case (cmd_i.op)
      OP_SEL:      direct = 1'b1;
      OP_INIT_SUM: begin
        a_row = src_q;
        a_col = dst_q;
      end
      OP_INIT_ROW: begin
        a_row = line_i;
        a_col = dst_q;
      end
      OP_INIT_COL: begin
        a_row = src_q;
        a_col = line_i;
      end
      OP_UPDATE: begin
        a_row = pick_row_q ? pick_q : line_i;
        a_col = pick_row_q ? line_i : pick_q;
      end
      default: ;
    endcase
    rd_addr = direct ? cmd_i.flat[AW-1:0]
                     : (AW'(a_row) * AW'(n_i) + AW'(a_col));
  end

  // Memories.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) cmem[cmd_i.flat[AW-1:0]] <= cell_i;
    cell_rd_q <= cmem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_q.op == OP_SEL_END) seed_mem[cmd_q.seed[SW-1:0]] <= {cand_r_q, cand_c_q};
    seed_rd_q <= seed_mem[cmd_i.seed[SW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    rps_rd_q <= rps[line_i];
    cps_rd_q <= cps[line_i];
    case (cmd_q.op)
      OP_INIT_ROW: rps[line_q] <= PSW'(cell_rd_q);
      OP_INIT_COL: cps[line_q] <= PSW'(cell_rd_q);
      OP_UPDATE: begin
        if (pick_row_q) begin
          if (!col_mark_q[line_q]) cps[line_q] <= cps_rd_q + PSW'(cell_rd_q);
        end else begin
          if (!row_mark_q[line_q]) rps[line_q] <= rps_rd_q + PSW'(cell_rd_q);
        end
      end
      default: ;
    endcase
  end

  // Ranking by count, then by the higher row-major index.
  assign sel_gt = (cell_rd_q > cand_cnt_q) ||
                  ((cell_rd_q == cand_cnt_q) && (cmd_q.flat[AW-1:0] > cand_flat_q));
  assign sel_lt = (cell_rd_q < lim_cnt_q) ||
                  ((cell_rd_q == lim_cnt_q) && (cmd_q.flat[AW-1:0] < lim_flat_q));
  assign sel_take = (first_q || sel_lt) && (!found_q || sel_gt);

  // A row beats a column of equal sum.
  assign take_row = hr_q && (!hc_q || (rv_q >= cv_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q      <= '0;
      first_q    <= 1'b1;
      found_q    <= 1'b0;
      hr_q       <= 1'b0;
      hc_q       <= 1'b0;
      row_mark_q <= '0;
      col_mark_q <= '0;
      best_q     <= '0;
      pick_row_q <= 1'b0;
    end else begin
      cmd_q <= cmd_i;
      if (score_done && (score_y > best_q)) best_q <= score_y;
      case (cmd_q.op)
        OP_SRCH_INIT: begin
          first_q <= 1'b1;
          best_q  <= '0;
        end
        OP_SEL_CLR: found_q <= 1'b0;
        OP_SEL:     if (sel_take) found_q <= 1'b1;
        OP_SEL_END: first_q <= 1'b0;
        OP_INIT_SUM: begin
          row_mark_q <= MATRIX_DIM'(1) << src_q;
          col_mark_q <= MATRIX_DIM'(1) << dst_q;
        end
        OP_SCAN_CLR: begin
          hr_q <= 1'b0;
          hc_q <= 1'b0;
        end
        OP_SCAN: begin
          if (!row_mark_q[line_q] && (!hr_q || (rps_rd_q >= rv_q))) hr_q <= 1'b1;
          if (!col_mark_q[line_q] && (!hc_q || (cps_rd_q >= cv_q))) hc_q <= 1'b1;
        end
        OP_DECIDE: begin
          pick_row_q <= take_row;
          if (take_row) row_mark_q[br_q] <= 1'b1;
          else          col_mark_q[bc_q] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    d_q <= DW'(rows_q) * DW'(cols_q);
    case (cmd_q.op)
      OP_SEL: begin
        if (sel_take) begin
          cand_cnt_q  <= cell_rd_q;
          cand_flat_q <= cmd_q.flat[AW-1:0];
          cand_r_q    <= cmd_q.row[LW-1:0];
          cand_c_q    <= cmd_q.col[LW-1:0];
        end
      end
      OP_SEL_END: begin
        lim_cnt_q  <= cand_cnt_q;
        lim_flat_q <= cand_flat_q;
      end
      OP_SEED_RD: {src_q, dst_q} <= seed_rd_q;
      OP_INIT_SUM: begin
        sum_q  <= SUMW'(cell_rd_q);
        rows_q <= NW'(1);
        cols_q <= NW'(1);
      end
      OP_SCAN: begin
        if (!row_mark_q[line_q] && (!hr_q || (rps_rd_q >= rv_q))) begin
          rv_q <= rps_rd_q;
          br_q <= line_q;
        end
        if (!col_mark_q[line_q] && (!hc_q || (cps_rd_q >= cv_q))) begin
          cv_q <= cps_rd_q;
          bc_q <= line_q;
        end
      end
      OP_DECIDE: begin
        if (take_row) begin
          pick_q <= br_q;
          rows_q <= rows_q + NW'(1);
          sum_q  <= sum_q + SUMW'(rv_q);
        end else begin
          pick_q <= bc_q;
          cols_q <= cols_q + NW'(1);
          sum_q  <= sum_q + SUMW'(cv_q);
        end
      end
      default: ;
    endcase
  end

  dsd_score #(
    .SUMW (SUMW),
    .DW   (DW)
  ) u_score (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_q.op == OP_SCORE_GO),
    .sum_i   (sum_q),
    .d_i     (d_q),
    .done_o  (score_done),
    .y_o     (score_y)
  );

  assign stat_o.score_done = score_done;
  assign best_o            = best_q;

endmodule

FILE: rtl/dsd_ctrl.sv
// ----------------------------------------------------------------------------
// Density controller
// Sequences the load, seed selection passes, growth rounds and result hand-off.
// ----------------------------------------------------------------------------
module dsd_ctrl #(
  parameter int MATRIX_DIM = 32,
  parameter int MAX_SEEDS  = 64,
  localparam int NW        = $clog2(MATRIX_DIM + 1),
  localparam int TW        = $clog2(MATRIX_DIM * MATRIX_DIM + 1),
  localparam int KW        = $clog2(MAX_SEEDS + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [NW-1:0]  n_i,
  input  logic [TW-1:0]  total_i,
  input  logic [KW-1:0]  k_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_free_i,
  output logic           out_load_o,
  input  dsd_pkg::stat_t stat_i,
  output dsd_pkg::cmd_t  cmd_o
);
  import dsd_pkg::*;

  localparam int LW = $clog2(MATRIX_DIM);
  localparam int AW = $clog2(MATRIX_DIM * MATRIX_DIM);
  localparam int RW = LW + 1;

  state_e state_q, state_d, gap_to_q, gap_to_d;

  logic [AW-1:0] load_pos_q, flat_q;
  logic [LW-1:0] r_q, c_q, line_q;
  logic          phase_q;
  logic [KW-1:0] seed_q;
  logic [RW-1:0] rnd_q;

  logic load_last, flat_last, line_last, c_last, seed_last, rnd_last, accept;

  assign accept    = (state_q == S_LOAD) && in_valid_i;
  assign load_last = (TW'(load_pos_q) + TW'(1)) >= total_i;
  assign flat_last = (TW'(flat_q) + TW'(1)) == total_i;
  assign line_last = NW'(line_q) == (n_i - NW'(1));
  assign c_last    = NW'(c_q) == (n_i - NW'(1));
  assign seed_last = (seed_q + KW'(1)) == k_i;
  assign rnd_last  = (NW + 1)'(rnd_q) == ({n_i, 1'b0} - (NW + 1)'(2));

  always_comb begin
    state_d  = state_q;
    gap_to_d = gap_to_q;
    unique case (state_q)
      S_LOAD:      if (accept && load_last) state_d = S_SRCH_INIT;
      S_SRCH_INIT: begin
        state_d  = S_GAP;
        gap_to_d = (k_i == '0) ? S_DONE : S_SEL_CLR;
      end
      S_GAP:       state_d = gap_to_q;
      S_SEL_CLR:   state_d = S_SEL;
      S_SEL:       if (flat_last) state_d = S_SEL_END;
      S_SEL_END: begin
        if (seed_last) begin
          state_d  = S_GAP;
          gap_to_d = S_SEED_RD;
        end else begin
          state_d = S_SEL_CLR;
        end
      end
      S_SEED_RD: begin
        state_d  = S_GAP;
        gap_to_d = S_INIT_SUM;
      end
      S_INIT_SUM:   state_d = S_INIT_LINES;
      S_INIT_LINES: if (phase_q && line_last) state_d = S_SCORE_GO;
      S_SCORE_GO:   state_d = S_SCORE_WAIT;
      S_SCORE_WAIT: begin
        if (stat_i.score_done) begin
          if (!rnd_last)      state_d = S_SCAN_CLR;
          else if (seed_last) state_d = S_DONE;
          else                state_d = S_SEED_RD;
        end
      end
      S_SCAN_CLR: state_d = S_SCAN;
      S_SCAN:     if (line_last) state_d = S_DECIDE;
      S_DECIDE: begin
        state_d  = S_GAP;
        gap_to_d = S_UPDATE;
      end
      S_UPDATE:   if (line_last) state_d = S_SCORE_GO;
      S_DONE:     if (out_free_i) state_d = S_LOAD;
      default:    state_d = S_LOAD;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.op   = OP_NONE;
    cmd_o.flat = FLAT_W_MAX'((state_q == S_LOAD) ? load_pos_q : flat_q);
    cmd_o.row  = LINE_W_MAX'((state_q == S_SEL) ? r_q : line_q);
    cmd_o.col  = LINE_W_MAX'(c_q);
    cmd_o.seed = SEED_W_MAX'(seed_q);
    in_ready_o = (state_q == S_LOAD);
    out_load_o = (state_q == S_DONE) && out_free_i;
    unique case (state_q)
      S_LOAD:       if (in_valid_i) cmd_o.op = OP_LOAD;
      S_SRCH_INIT:  cmd_o.op = OP_SRCH_INIT;
      S_SEL_CLR:    cmd_o.op = OP_SEL_CLR;
      S_SEL:        cmd_o.op = OP_SEL;
      S_SEL_END:    cmd_o.op = OP_SEL_END;
      S_SEED_RD:    cmd_o.op = OP_SEED_RD;
      S_INIT_SUM:   cmd_o.op = OP_INIT_SUM;
      S_INIT_LINES: cmd_o.op = phase_q ? OP_INIT_COL : OP_INIT_ROW;
      S_SCORE_GO:   cmd_o.op = OP_SCORE_GO;
      S_SCAN_CLR:   cmd_o.op = OP_SCAN_CLR;
      S_SCAN:       cmd_o.op = OP_SCAN;
      S_DECIDE:     cmd_o.op = OP_DECIDE;
      S_UPDATE:     cmd_o.op = OP_UPDATE;
      default:      cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      gap_to_q   <= S_LOAD;
      load_pos_q <= '0;
      flat_q     <= '0;
      r_q        <= '0;
      c_q        <= '0;
      line_q     <= '0;
      phase_q    <= 1'b0;
      seed_q     <= '0;
      rnd_q      <= '0;
    end else begin
      state_q  <= state_d;
      gap_to_q <= gap_to_d;
      case (state_q)
        S_LOAD: begin
          if (accept) load_pos_q <= load_last ? '0 : load_pos_q + AW'(1);
        end
        S_SRCH_INIT: seed_q <= '0;
        S_SEL_CLR: begin
          flat_q <= '0;
          r_q    <= '0;
          c_q    <= '0;
        end
        S_SEL: begin
          flat_q <= flat_q + AW'(1);
          if (c_last) begin
            c_q <= '0;
            r_q <= r_q + LW'(1);
          end else begin
            c_q <= c_q + LW'(1);
          end
        end
        S_SEL_END: seed_q <= seed_last ? '0 : seed_q + KW'(1);
        S_SEED_RD: rnd_q <= '0;
        S_INIT_SUM: begin
          line_q  <= '0;
          phase_q <= 1'b0;
        end
        S_INIT_LINES: begin
          phase_q <= !phase_q;
          if (phase_q) line_q <= line_q + LW'(1);
        end
        S_SCORE_WAIT: begin
          if (stat_i.score_done && rnd_last) seed_q <= seed_q + KW'(1);
        end
        S_SCAN_CLR: line_q <= '0;
        S_SCAN:     line_q <= line_q + LW'(1);
        S_DECIDE: begin
          rnd_q  <= rnd_q + RW'(1);
          line_q <= '0;
        end
        S_UPDATE: line_q <= line_q + LW'(1);
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/dense_submatrix_density_core.sv
// ----------------------------------------------------------------------------
// Dense submatrix density core
// Loads a square count matrix and reports the best greedy-peeled density.
// ----------------------------------------------------------------------------
// Usage: write top_k (index 0) and matrix_size (index 1) through the cfg port
// while the core is idle. Then send matrix_size squared cell counts on cell_i,
// one word per cycle, in row-major order. Cells are written to an on-chip
// memory at one word per cycle, so the load phase runs at full rate.
// After the last cell the core stops taking words and runs the search:
// each of the k seeds takes one full scan of the cell memory. Growth from
// each seed loads its cell and the row and column partial sums as setup
// and then 2n-2 rounds that scan the lines, add the best one and update
// the partial sums. The setup and every round are followed by a score,
// a bit-serial square and a root with an add and a compare per result bit.
// The single result word then goes to an output register on density_o; the
// core accepts the next matrix as soon as that register has been loaded.
// If the receiver stalls and the register still holds the previous result
// when a new search finishes, the core waits until that word is taken.
// Reset clears the load position, the control state and the output valid bit
// and restores top_k to 1 and matrix_size to 32; cell memory is not cleared.
// ----------------------------------------------------------------------------
module dense_submatrix_density_core #(
  parameter int MATRIX_DIM  = 32,
  parameter int COUNT_WIDTH = 24,
  parameter int MAX_SEEDS   = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dsd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dsd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  dsd_in_if.sink                         cell_i,
  dsd_out_if.source                      density_o
);
  import dsd_pkg::*;

  localparam int NW    = $clog2(MATRIX_DIM + 1);
  localparam int TW    = $clog2(MATRIX_DIM * MATRIX_DIM + 1);
  localparam int KW    = $clog2(MAX_SEEDS + 1);
  localparam int CMPW  = (NW > MSIZE_W) ? NW : MSIZE_W;
  localparam int KCW   = TW + 8;

  logic [TOPK_W-1:0]  top_k_q;
  logic [MSIZE_W-1:0] msize_q;
  logic [NW-1:0]      n;
  logic [CMPW-1:0]    n_full;
  logic [TW-1:0]      total;
  logic [KCW-1:0]     k_full;
  logic [KW-1:0]      k;

  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q;
  logic             out_free, out_load;
  logic [OUT_W-1:0] best;

  cmd_t  cmd;
  stat_t stat;

  // Configuration registers; writes outside the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_k_q <= TOP_K_RST;
      msize_q <= MSIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TOP_K:       top_k_q <= cfg_data_i[TOPK_W-1:0];
        CFG_MATRIX_SIZE: msize_q <= cfg_data_i[MSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // The matrix size is clamped to [2, MATRIX_DIM] and the seed count to the
  // number of cells and to the seed memory depth.
  always_comb begin
    n_full = CMPW'(msize_q);
    if (n_full < CMPW'(2))               n_full = CMPW'(2);
    else if (n_full > CMPW'(MATRIX_DIM)) n_full = CMPW'(MATRIX_DIM);
    n     = NW'(n_full);
    total = TW'(n) * TW'(n);
    k_full = KCW'(top_k_q);
    if (k_full > KCW'(total))     k_full = KCW'(total);
    if (k_full > KCW'(MAX_SEEDS)) k_full = KCW'(MAX_SEEDS);
    k = KW'(k_full);
  end

  dsd_ctrl #(
    .MATRIX_DIM (MATRIX_DIM),
    .MAX_SEEDS  (MAX_SEEDS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .n_i        (n),
    .total_i    (total),
    .k_i        (k),
    .in_valid_i (cell_i.valid),
    .in_ready_o (cell_i.ready),
    .out_free_i (out_free),
    .out_load_o (out_load),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dsd_datapath #(
    .MATRIX_DIM  (MATRIX_DIM),
    .COUNT_WIDTH (COUNT_WIDTH),
    .MAX_SEEDS   (MAX_SEEDS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .n_i    (n),
    .cell_i (cell_i.cell_count),
    .stat_o (stat),
    .best_o (best)
  );

  // Output register: the result word waits here while the core goes on.
  assign out_free = !out_valid_q || density_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (density_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_data_q <= best;
  end

  assign density_o.valid        = out_valid_q;
  assign density_o.best_density = out_data_q;

endmodule
